[sv/esl_pkg.sv]
// Shared types, constants and the escape table of the stream escaper.
package esl_pkg;

   localparam int OFFSET_WIDTH_DEF = 16;
   localparam int ESC_MAX_LEN      = 6;
   localparam int ESC_LEN_W        = $clog2(ESC_MAX_LEN + 1);
   localparam int CAP_W            = 16;
   localparam int LIMIT_W          = 16;
   localparam int WOULD_W          = 24;
   localparam int OFFS_OUT_W       = 16;
   localparam int CSR_ADDR_W       = 3;
   localparam int CSR_DATA_W       = 32;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = 16'hFFFF;
   localparam logic             CSR_IDX_CAPACITY = 1'b0;

   localparam logic MODE_QUOTE = 1'b0;
   localparam logic MODE_HTML  = 1'b1;

   localparam logic [7:0] CH_SQ  = 8'h27;
   localparam logic [7:0] CH_DQ  = 8'h22;
   localparam logic [7:0] CH_LT  = 8'h3C;
   localparam logic [7:0] CH_GT  = 8'h3E;
   localparam logic [7:0] CH_AMP = 8'h26;
   localparam logic [7:0] CH_NUL = 8'h00;

   typedef logic [ESC_MAX_LEN-1:0][7:0] esc_text_type;

   // element 0 is the first byte emitted
   localparam esc_text_type SEQ_SQ   = {8'h00, 8'h00, 8'h00, 8'h00, "'", "\\"};
   localparam esc_text_type SEQ_DQ   = {8'h00, 8'h00, 8'h00, 8'h00, "\"", "\\"};
   localparam esc_text_type SEQ_LT   = {8'h00, 8'h00, ";", "t", "l", "&"};
   localparam esc_text_type SEQ_GT   = {8'h00, 8'h00, ";", "t", "g", "&"};
   localparam esc_text_type SEQ_AMP  = {8'h00, ";", "p", "m", "a", "&"};
   localparam esc_text_type SEQ_QUOT = {";", "t", "o", "u", "q", "&"};
   localparam esc_text_type SEQ_APOS = {8'h00, ";", "9", "3", "#", "&"};
   localparam esc_text_type SEQ_NUL  = {8'h00, 8'h00, ";", "0", "#", "&"};

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        first_byte;
      logic        end_of_string;
      logic        table_mode;
      logic [15:0] output_limit;
      logic        limit_off;
      logic [15:0] start_offset;
      logic        start_stopped;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic        last_of_run;
      logic [23:0] would_length;
      logic [15:0] written_offset;
      logic        space_exhausted;
      logic        string_done;
   } rsp_payload_type;

   typedef struct packed {
      logic [ESC_LEN_W-1:0] len;
      esc_text_type         text;
   } esc_type;

   // one accepted byte, fully resolved: what to emit and the status it reports
   typedef struct packed {
      esc_text_type           text;
      logic [ESC_LEN_W-1:0]   count;
      logic                   byte_valid;
      logic [WOULD_W-1:0]     would_length;
      logic [OFFS_OUT_W-1:0]  written_offset;
      logic                   space_exhausted;
      logic                   string_done;
   } seq_type;

   function automatic esc_type esl_lookup(logic mode, logic [7:0] b);
      esc_type r;
      r.len  = ESC_LEN_W'(1);
      r.text = esc_text_type'(b);
      if (mode == MODE_QUOTE) begin
         case (b)
            CH_SQ: begin r.len = ESC_LEN_W'(2); r.text = SEQ_SQ; end
            CH_DQ: begin r.len = ESC_LEN_W'(2); r.text = SEQ_DQ; end
            default: ;
         endcase
      end else begin
         case (b)
            CH_LT:  begin r.len = ESC_LEN_W'(4); r.text = SEQ_LT;   end
            CH_GT:  begin r.len = ESC_LEN_W'(4); r.text = SEQ_GT;   end
            CH_AMP: begin r.len = ESC_LEN_W'(5); r.text = SEQ_AMP;  end
            CH_DQ:  begin r.len = ESC_LEN_W'(6); r.text = SEQ_QUOT; end
            CH_SQ:  begin r.len = ESC_LEN_W'(5); r.text = SEQ_APOS; end
            CH_NUL: begin r.len = ESC_LEN_W'(4); r.text = SEQ_NUL;  end
            default: ;
         endcase
      end
      return r;
   endfunction

endpackage

[sv/esl_req_if.sv]
// Source byte channel: valid/ready handshake with the request payload.
interface esl_req_if;
   import esl_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

[sv/esl_rsp_if.sv]
// Result channel: valid/ready handshake with one emitted byte and its status.
interface esl_rsp_if;
   import esl_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

[sv/esl_core.sv]
// Per-string state and the escape, limit and capacity decision for one byte.
module esl_core #(
   parameter int OFFSET_WIDTH = esl_pkg::OFFSET_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  esl_pkg::req_payload_type  req,
   input  logic [esl_pkg::CAP_W-1:0] capacity,
   output esl_pkg::seq_type          seq
);
   import esl_pkg::*;

   localparam int CMP_W = (OFFSET_WIDTH + 1 > CAP_W) ? OFFSET_WIDTH + 1 : CAP_W;

   logic [LIMIT_W-1:0]      remaining_limit_ff, remaining_limit_in;
   logic                    limit_disabled_ff, limit_disabled_in;
   logic [OFFSET_WIDTH-1:0] write_offset_ff, write_offset_in;
   logic                    stopped_flag_ff, stopped_flag_in;
   logic [WOULD_W-1:0]      would_count_ff, would_count_in;
   logic                    mode_ff, mode_in;

   logic [LIMIT_W-1:0]      rem;
   logic [OFFSET_WIDTH-1:0] offs;
   logic                    stop;
   logic [WOULD_W-1:0]      would;
   esc_type                 esc;
   logic                    fits;
   logic                    room;
   logic                    do_write;
   logic [WOULD_W:0]        would_sum;

   always_comb begin
      // a first byte loads the per-string settings before it is itself processed
      mode_in           = req.first_byte ? req.table_mode : mode_ff;
      rem               = req.first_byte ? req.output_limit : remaining_limit_ff;
      limit_disabled_in = req.first_byte ? req.limit_off : limit_disabled_ff;
      offs              = req.first_byte ? OFFSET_WIDTH'(req.start_offset) : write_offset_ff;
      stop              = req.first_byte ? req.start_stopped : stopped_flag_ff;
      would             = req.first_byte ? '0 : would_count_ff;

      esc  = esl_lookup(mode_in, req.data_byte);
      fits = limit_disabled_in || (rem >= LIMIT_W'(esc.len));
      room = (CMP_W'(offs) + CMP_W'(esc.len) + CMP_W'(1)) <= CMP_W'(capacity);
      do_write = fits && !stop && room;

      would_sum      = {1'b0, would} + (WOULD_W + 1)'(esc.len);
      would_count_in = !fits ? would : (would_sum[WOULD_W] ? '1 : would_sum[WOULD_W-1:0]);
      write_offset_in    = do_write ? offs + OFFSET_WIDTH'(esc.len) : offs;
      remaining_limit_in = (do_write && !limit_disabled_in) ? rem - LIMIT_W'(esc.len) : rem;
      stopped_flag_in    = stop || (fits && !do_write);

      seq.text            = esc.text;
      seq.count           = do_write ? esc.len : ESC_LEN_W'(1);
      seq.byte_valid      = do_write;
      seq.would_length    = would_count_in;
      seq.written_offset  = OFFS_OUT_W'(write_offset_in);
      seq.space_exhausted = stopped_flag_in;
      seq.string_done     = req.end_of_string;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_limit_ff <= '0;
         limit_disabled_ff  <= 1'b0;
         write_offset_ff    <= '0;
         stopped_flag_ff    <= 1'b0;
         would_count_ff     <= '0;
         mode_ff            <= MODE_QUOTE;
      end else if (accept) begin
         remaining_limit_ff <= remaining_limit_in;
         limit_disabled_ff  <= limit_disabled_in;
         write_offset_ff    <= write_offset_in;
         stopped_flag_ff    <= stopped_flag_in;
         would_count_ff     <= would_count_in;
         mode_ff            <= mode_in;
      end
   end

endmodule

[sv/escape_stream_with_limit_top.sv]
// Top level of the stream escaper: request intake, result drain and register port.
//
//   channel  | dir | handshake               | carries
//   ---------+-----+-------------------------+---------------------------------
//   req_chan | in  | valid & ready           | one source byte + string settings
//   rsp_chan | out | valid & ready           | one emitted byte or empty status
//   APB      | in  | psel & penable & pready | buffer_capacity at address 0
//
// A byte is decided in the cycle it is accepted and lands in the result register.
// A plain or dropped byte gives one result, an escape gives up to six, one per cycle
// while rsp_chan is ready; the input is taken again in the cycle the last result of
// the run transfers. Stalls on rsp_chan hold the result register and back up into
// req_chan. Reset is synchronous and clears all per-string state.
module escape_stream_with_limit_top #(
   parameter int OFFSET_WIDTH = esl_pkg::OFFSET_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   esl_req_if.sink                        req_chan,
   esl_rsp_if.source                      rsp_chan,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [esl_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [esl_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [esl_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import esl_pkg::*;

   logic [CAP_W-1:0] capacity_ff;
   logic             pend_valid_ff;
   seq_type          pend_ff;
   seq_type          seq;
   logic             req_accept;
   logic             rsp_xfer;
   logic             last_beat;

   // register port
   assign pready = 1'b1;
   assign prdata = (paddr[CSR_ADDR_W-1] == CSR_IDX_CAPACITY) ?
                   CSR_DATA_W'(capacity_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else if (psel && penable && pwrite && pready &&
                   paddr[CSR_ADDR_W-1] == CSR_IDX_CAPACITY) begin
         capacity_ff <= pwdata[CAP_W-1:0];
      end
   end

   esl_core #(
      .OFFSET_WIDTH(OFFSET_WIDTH)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .accept   (req_accept),
      .req      (req_chan.data),
      .capacity (capacity_ff),
      .seq      (seq)
   );

   assign last_beat      = (pend_ff.count == ESC_LEN_W'(1));
   assign rsp_xfer       = pend_valid_ff && rsp_chan.ready;
   assign req_chan.ready = !pend_valid_ff || (rsp_chan.ready && last_beat);
   assign req_accept     = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (req_accept) begin
         pend_valid_ff <= 1'b1;
      end else if (rsp_xfer && last_beat) begin
         pend_valid_ff <= 1'b0;
      end
   end

   // drain: shift the escape text down one byte per transfer
   always_ff @(posedge clock) begin
      if (req_accept) begin
         pend_ff <= seq;
      end else if (rsp_xfer && !last_beat) begin
         pend_ff.text  <= {8'h00, pend_ff.text[ESC_MAX_LEN-1:1]};
         pend_ff.count <= pend_ff.count - ESC_LEN_W'(1);
      end
   end

   assign rsp_chan.valid                = pend_valid_ff;
   assign rsp_chan.data.out_byte        = pend_ff.byte_valid ? pend_ff.text[0] : 8'h00;
   assign rsp_chan.data.byte_valid      = pend_ff.byte_valid;
   assign rsp_chan.data.last_of_run     = last_beat;
   assign rsp_chan.data.would_length    = pend_ff.would_length;
   assign rsp_chan.data.written_offset  = pend_ff.written_offset;
   assign rsp_chan.data.space_exhausted = pend_ff.space_exhausted;
   assign rsp_chan.data.string_done     = last_beat && pend_ff.string_done;

`ifndef ASSERT_OFF
   a_empty_single: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff && !pend_ff.byte_valid |-> last_beat)
      else $error("empty result spans more than one beat");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (pend_ff.count != '0) && (pend_ff.count <= ESC_LEN_W'(ESC_MAX_LEN)))
      else $error("beat count out of range");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && !last_beat |=> rsp_chan.valid && pend_ff.byte_valid)
      else $error("escape run broken before its last byte");

   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> pend_valid_ff)
      else $error("accepted byte produced no result");
`endif

endmodule

[bench/tb.sv]
// Self-checking bench for the stream escaper: random strings, capacity writes, stalls.
`timescale 1ns / 1ps

module tb;
   import esl_pkg::*;

   localparam int unsigned WOULD_MAX    = 24'hFFFFFF;
   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned PHASE_ITEMS  = 80;

   logic clock;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   esl_req_if req_chan();
   esl_rsp_if rsp_chan();

   escape_stream_with_limit_top dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   req_payload_type src_bytes[$];
   rsp_payload_type escaped_out[$];
   int unsigned bytes_sent;
   int unsigned bytes_taken;
   int unsigned mismatches;
   int unsigned cycle_count;
   int unsigned send_idle_pct;
   int unsigned rsp_idle_pct;
   logic pressure_on;
   int unsigned hold_left;
   logic hold_done;

   // escaper state as the block should hold it
   logic                  esc_mode;
   logic [LIMIT_W-1:0]    limit_left;
   logic                  limit_free;
   logic [OFFS_OUT_W-1:0] buf_offset;
   logic                  buf_stopped;
   logic [WOULD_W-1:0]    would_len;
   logic [CAP_W-1:0]      buf_capacity;

   logic [7:0] special_chars[6] = '{CH_SQ, CH_DQ, CH_LT, CH_GT, CH_AMP, CH_NUL};

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // empty string means the byte passes through unchanged
   function automatic string entity_for(logic mode, logic [7:0] b);
      if (mode == MODE_QUOTE) begin
         case (b)
            CH_SQ:   return "\\'";
            CH_DQ:   return "\\\"";
            default: return "";
         endcase
      end
      case (b)
         CH_LT:   return "&lt;";
         CH_GT:   return "&gt;";
         CH_AMP:  return "&amp;";
         CH_DQ:   return "&quot;";
         CH_SQ:   return "&#39;";
         CH_NUL:  return "&#0;";
         default: return "";
      endcase
   endfunction

   task automatic escape_byte(input req_payload_type item);
      string repl;
      int unsigned len;
      int unsigned n;
      rsp_payload_type res;
      if (item.first_byte) begin
         esc_mode    = item.table_mode;
         limit_left  = item.output_limit;
         limit_free  = item.limit_off;
         buf_offset  = item.start_offset;
         buf_stopped = item.start_stopped;
         would_len   = '0;
      end
      repl = entity_for(esc_mode, item.data_byte);
      len = (repl.len() == 0) ? 1 : repl.len();
      n = 0;
      // a replacement that misses the limit is dropped whole and not counted
      if (limit_free || limit_left >= len) begin
         if (32'(would_len) + len > WOULD_MAX)
            would_len = WOULD_W'(WOULD_MAX);
         else
            would_len = would_len + WOULD_W'(len);
         if (!buf_stopped && 32'(buf_offset) + len + 1 <= 32'(buf_capacity)) begin
            n = len;
            buf_offset = buf_offset + OFFS_OUT_W'(len);
            if (!limit_free)
               limit_left = limit_left - LIMIT_W'(len);
         end else begin
            buf_stopped = 1'b1;
         end
      end
      res.would_length    = would_len;
      res.written_offset  = buf_offset;
      res.space_exhausted = buf_stopped;
      if (n == 0) begin
         res.out_byte    = 8'h00;
         res.byte_valid  = 1'b0;
         res.last_of_run = 1'b1;
         res.string_done = item.end_of_string;
         escaped_out.push_back(res);
      end else begin
         for (int unsigned k = 0; k < n; k++) begin
            res.out_byte    = (repl.len() == 0) ? item.data_byte : repl[k];
            res.byte_valid  = 1'b1;
            res.last_of_run = (k == n - 1);
            res.string_done = (k == n - 1) && item.end_of_string;
            escaped_out.push_back(res);
         end
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endtask

   // monitor: results first, then the source byte taken at the same edge
   always @(posedge clock) begin : monitor
      rsp_payload_type want;
      if (reset) begin
         esc_mode    = MODE_QUOTE;
         limit_left  = '0;
         limit_free  = 1'b0;
         buf_offset  = '0;
         buf_stopped = 1'b0;
         would_len   = '0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (escaped_out.size() == 0) begin
               $error("unexpected transfer: out_byte %0h", rsp_chan.data.out_byte);
               mismatches++;
            end else begin
               want = escaped_out.pop_front();
               check_field("out_byte", want.out_byte, rsp_chan.data.out_byte);
               check_field("byte_valid", want.byte_valid, rsp_chan.data.byte_valid);
               check_field("last_of_run", want.last_of_run, rsp_chan.data.last_of_run);
               check_field("would_length", want.would_length, rsp_chan.data.would_length);
               check_field("written_offset", want.written_offset,
                           rsp_chan.data.written_offset);
               check_field("space_exhausted", want.space_exhausted,
                           rsp_chan.data.space_exhausted);
               check_field("string_done", want.string_done, rsp_chan.data.string_done);
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            escape_byte(req_chan.data);
            bytes_taken <= bytes_taken + 1;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || bytes_taken == bytes_sent) begin
         if (src_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_chan.data  <= src_bytes.pop_front();
            req_chan.valid <= 1'b1;
            bytes_sent     <= bytes_sent + 1;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // receiver; one long hold-off while the sender keeps offering
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (pressure_on && !hold_done && src_bytes.size() > 20) begin
         rsp_chan.ready <= 1'b0;
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(4 * CSR_IDX_CAPACITY);
      pwdata  <= CSR_DATA_W'(value);
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      buf_capacity = value;
   endtask

   task automatic wait_drained();
      while (src_bytes.size() != 0 || req_chan.valid || escaped_out.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic queue_first(input logic [7:0] b, input logic eos, input logic mode,
                              input logic [15:0] lim, input logic loff,
                              input logic [15:0] offs, input logic stopped);
      req_payload_type r;
      r.data_byte     = b;
      r.first_byte    = 1'b1;
      r.end_of_string = eos;
      r.table_mode    = mode;
      r.output_limit  = lim;
      r.limit_off     = loff;
      r.start_offset  = offs;
      r.start_stopped = stopped;
      src_bytes.push_back(r);
   endtask

   task automatic queue_next(input logic [7:0] b, input logic eos);
      req_payload_type r;
      r = '0;
      r.data_byte     = b;
      r.end_of_string = eos;
      src_bytes.push_back(r);
   endtask

   function automatic req_payload_type random_item();
      logic [63:0] raw;
      req_payload_type r;
      raw = {$urandom, $urandom};
      r = raw[$bits(req_payload_type)-1:0];
      return r;
   endfunction

   task automatic queue_random_strings(input int unsigned count, input logic [CAP_W-1:0] cap);
      req_payload_type r;
      int unsigned made;
      int unsigned len;
      made = 0;
      while (made < count) begin
         if ($urandom_range(9) == 0) begin
            src_bytes.push_back(random_item());
            made++;
         end else begin
            len = $urandom_range(1, 10);
            for (int unsigned k = 0; k < len; k++) begin
               r = random_item();
               r.first_byte = (k == 0);
               // an early end mark leaves the string running
               r.end_of_string = (k == len - 1) || ($urandom_range(15) == 0);
               if ($urandom_range(1))
                  r.data_byte = special_chars[$urandom_range(5)];
               if (k == 0) begin
                  r.output_limit  = ($urandom_range(3) == 0) ? 16'($urandom)
                                                             : 16'($urandom_range(0, 24));
                  r.limit_off     = ($urandom_range(3) == 0);
                  r.start_stopped = ($urandom_range(7) == 0);
                  case ($urandom_range(2))
                     0:       r.start_offset = cap - 16'($urandom_range(0, 30));
                     1:       r.start_offset = 16'($urandom_range(0, 64));
                     default: r.start_offset = 16'($urandom);
                  endcase
               end
               src_bytes.push_back(r);
               made++;
            end
         end
      end
   endtask

   initial begin
      logic [CAP_W-1:0] cap;
      req_chan.valid = 1'b0;
      req_chan.data  = '0;
      rsp_chan.ready = 1'b0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      reset          = 1'b1;
      bytes_sent     = 0;
      bytes_taken    = 0;
      mismatches     = 0;
      cycle_count    = 0;
      hold_left      = 0;
      hold_done      = 1'b0;
      pressure_on    = 1'b0;
      send_idle_pct  = 8;
      rsp_idle_pct   = 69;
      buf_capacity   = CAPACITY_RESET;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // no string started yet: limit 0, everything dropped
      queue_next("a", 1'b0);
      queue_next(CH_LT, 1'b0);
      // quote mode, no limit; NUL passes through
      queue_first(CH_SQ, 1'b0, MODE_QUOTE, 16'd0, 1'b1, 16'd0, 1'b0);
      queue_next(CH_DQ, 1'b0);
      queue_next(CH_NUL, 1'b0);
      queue_next(8'hFF, 1'b0);
      queue_next("A", 1'b1);
      queue_next(CH_DQ, 1'b0);
      // entity mode, limit runs out
      queue_first(CH_LT, 1'b0, MODE_HTML, 16'd9, 1'b0, 16'd0, 1'b0);
      queue_next(CH_AMP, 1'b0);
      queue_next(CH_GT, 1'b0);
      queue_next("x", 1'b1);
      // capacity runs out mid string
      queue_first(CH_DQ, 1'b0, MODE_HTML, 16'hFFFF, 1'b0, 16'hFFF0, 1'b0);
      queue_next(CH_SQ, 1'b0);
      queue_next(CH_NUL, 1'b0);
      queue_next("b", 1'b1);
      // offset at capacity, buffer already exhausted, zero limit
      queue_first("c", 1'b1, MODE_HTML, 16'd0, 1'b1, 16'hFFFF, 1'b0);
      queue_first(CH_SQ, 1'b1, MODE_QUOTE, 16'd0, 1'b1, 16'd0, 1'b1);
      queue_first("d", 1'b1, MODE_QUOTE, 16'd0, 1'b0, 16'd0, 1'b0);
      wait_drained();

      // capacity too small for anything
      write_capacity(16'd1);
      queue_first("e", 1'b0, MODE_QUOTE, 16'd0, 1'b1, 16'd0, 1'b0);
      queue_next("f", 1'b1);
      wait_drained();
      write_capacity(16'd0);
      queue_first("g", 1'b1, MODE_HTML, 16'hFFFF, 1'b0, 16'd0, 1'b0);
      wait_drained();

      send_idle_pct = 8;
      rsp_idle_pct  = 69;
      write_capacity(16'hFFFF);
      queue_random_strings(PHASE_ITEMS, 16'hFFFF);
      wait_drained();

      send_idle_pct = 69;
      rsp_idle_pct  = 8;
      cap = 16'($urandom_range(2, 300));
      write_capacity(cap);
      queue_random_strings(PHASE_ITEMS, cap);
      wait_drained();

      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      pressure_on   = 1'b1;
      cap = 16'($urandom_range(1, 65535));
      write_capacity(cap);
      queue_random_strings(PHASE_ITEMS, cap);
      wait_drained();

      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
